// File: rtl/core/nnfs_pkg.sv
// Shared constants, types and codes for the nearest-neighbor frame scaler.
`default_nettype none

package nnfs_pkg;

    localparam int MAX_DIM          = 4096;
    localparam int MAX_SPAN_DEFAULT = 8;

    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int CNT_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 24;
    localparam int DATA_W  = 32;
    localparam int APB_DW  = 32;
    localparam int NUM_REGS = 5;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int PADDR_W = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_DEST_WIDTH  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_DEST_HEIGHT = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH   = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT  = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_PIXEL_MODE  = REG_IDX_W'(4);

    localparam logic [DIM_W-1:0] RST_DEST_WIDTH  = DIM_W'(1920);
    localparam logic [DIM_W-1:0] RST_DEST_HEIGHT = DIM_W'(1080);
    localparam logic [DIM_W-1:0] RST_SRC_WIDTH   = DIM_W'(1920);
    localparam logic [DIM_W-1:0] RST_SRC_HEIGHT  = DIM_W'(1080);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ROW_BEGIN,
        S_ROW_END,
        S_COL_BEGIN,
        S_COL_END,
        S_SETUP,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        DIV_ROW_BEGIN,
        DIV_ROW_END,
        DIV_COL_BEGIN,
        DIV_COL_END
    } t_div_sel;

    // effective (clamped) dimensions and mode
    typedef struct packed {
        logic [DIM_W-1:0] dw;
        logic [DIM_W-1:0] dh;
        logic [DIM_W-1:0] sw;
        logic [DIM_W-1:0] sh;
        logic             mode;
    } t_cfg;

    typedef struct packed {
        logic     accept;
        logic     div_start;
        t_div_sel div_sel;
        logic     col_reuse;
        logic     setup;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic row_hit;
        logic col_hit;
        logic span_zero;
        logic out_free;
        logic beat_last;
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/core/nnfs_div.sv
// Restoring divider, one quotient bit per cycle, for quotients that fit DIM_W bits.
`default_nettype none

module nnfs_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [2*nnfs_pkg::DIM_W-1:0] i_numer,
    input  wire logic [nnfs_pkg::DIM_W-1:0]   i_denom,
    output logic                              o_done,
    output logic [nnfs_pkg::DIM_W-1:0]        o_quot
);
    import nnfs_pkg::*;

    localparam int CW = $clog2(DIM_W);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DIM_W-1:0]  r_rem;
    logic [DIM_W-1:0]  r_quo;
    logic [DIM_W-1:0]  r_den;

    logic [DIM_W:0]    trial;
    logic              ge;
    logic [DIM_W-1:0]  n_rem;

    // numerator high half is below the divisor, so DIM_W steps give the quotient
    always_comb begin
        trial = {r_rem, r_quo[DIM_W-1]};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? DIM_W'(trial - {1'b0, r_den}) : trial[DIM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(DIM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_numer[2*DIM_W-1:DIM_W];
            r_quo <= i_numer[DIM_W-1:0];
            r_den <= i_denom;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

// File: rtl/core/nnfs_ctrl.sv
// Sequencer: per pixel, runs the needed divisions, then issues the write beats.
`default_nettype none

module nnfs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire nnfs_pkg::t_sts i_sts,
    output nnfs_pkg::t_cmd     o_cmd
);
    import nnfs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        o_cmd   = '0;
        o_cmd.div_sel = DIV_COL_END;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.col_reuse = i_sts.col_hit;
                o_cmd.div_start = 1'b1;
                if (!i_sts.row_hit) begin
                    o_cmd.div_sel = DIV_ROW_BEGIN;
                    n_state       = S_ROW_BEGIN;
                end else if (!i_sts.col_hit) begin
                    o_cmd.div_sel = DIV_COL_BEGIN;
                    n_state       = S_COL_BEGIN;
                end else begin
                    o_cmd.div_sel = DIV_COL_END;
                    n_state       = S_COL_END;
                end
            end
            S_ROW_BEGIN: begin
                if (i_sts.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_ROW_END;
                    n_state         = S_ROW_END;
                end
            end
            S_ROW_END: begin
                if (i_sts.div_done) begin
                    o_cmd.div_start = 1'b1;
                    if (i_sts.col_hit) begin
                        o_cmd.div_sel = DIV_COL_END;
                        n_state       = S_COL_END;
                    end else begin
                        o_cmd.div_sel = DIV_COL_BEGIN;
                        n_state       = S_COL_BEGIN;
                    end
                end
            end
            S_COL_BEGIN: begin
                if (i_sts.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_COL_END;
                    n_state         = S_COL_END;
                end
            end
            S_COL_END: begin
                if (i_sts.div_done) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                // empty column span: pixel makes no write
                if (i_sts.span_zero) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.beat_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/nnfs_dp.sv
// Datapath: source counters, span caches, divider, address generation, output register.
`default_nettype none

module nnfs_dp #(
    parameter int MAX_SPAN = nnfs_pkg::MAX_SPAN_DEFAULT
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire nnfs_pkg::t_cfg               i_cfg,
    input  wire logic                         i_cfg_wr,
    input  wire nnfs_pkg::t_cmd               i_cmd,
    output nnfs_pkg::t_sts                    o_sts,
    input  wire logic [nnfs_pkg::DATA_W-1:0]  i_pixel,
    input  wire logic                         i_frame_start,
    input  wire logic                         i_stall,
    output logic                              o_valid,
    output logic [nnfs_pkg::ADDR_W-1:0]       o_address,
    output logic [nnfs_pkg::DATA_W-1:0]       o_data,
    output logic                              o_last
);
    import nnfs_pkg::*;

    localparam int SPAN_W = $clog2(MAX_SPAN + 1);

    function automatic logic [DATA_W-1:0] to_565(input logic [DATA_W-1:0] p);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = p[23:16];
        g = p[15:8];
        b = p[7:0];
        to_565 = {16'h0000, r[7:3], g[7:2], b[7:3]};
    endfunction

    // source position counters (state carried between pixels)
    logic [CNT_W-1:0]  r_col_cnt;
    logic [CNT_W-1:0]  r_row_cnt;
    // position of the pixel being worked on
    logic [CNT_W-1:0]  r_cur_x;
    logic [CNT_W-1:0]  r_cur_y;
    logic [DATA_W-1:0] r_data;

    // row cache: begin/end of row span for source row r_row_key
    logic              r_row_ok;
    logic [CNT_W-1:0]  r_row_key;
    logic [DIM_W-1:0]  r_row_begin;
    logic [DIM_W-1:0]  r_row_end;
    // column: end of last span doubles as start of column r_col_key
    logic              r_col_ok;
    logic [DIM_W-1:0]  r_col_key;
    logic [DIM_W-1:0]  r_col_begin;
    logic [DIM_W-1:0]  r_col_end;

    t_div_sel          r_div_sel;

    logic [SPAN_W-1:0] r_c_span;
    logic [SPAN_W-1:0] r_r_span;
    logic [SPAN_W-1:0] r_c;
    logic [SPAN_W-1:0] r_r;
    logic [ADDR_W-1:0] r_row_base;

    logic              r_out_valid;

    // accept-time counter resolution
    logic [DIM_W-1:0]  x0, y0, x1, y1, y2, nx, ny;

    logic [DIM_W-1:0]     div_k;
    logic [DIM_W-1:0]     div_d;
    logic [DIM_W-1:0]     div_s;
    logic [2*DIM_W-1:0]   div_numer;
    logic                 div_done;
    logic [DIM_W-1:0]     div_quot;

    logic [DIM_W-1:0]     col_diff;
    logic [DIM_W-1:0]     row_diff;
    logic [SPAN_W-1:0]    n_c_span;
    logic [SPAN_W-1:0]    n_r_span;
    logic [2*DIM_W-1:0]   base_prod;
    logic                 c_wrap;
    logic                 beat_last;
    logic                 out_free;

    always_comb begin
        x0 = i_frame_start ? '0 : DIM_W'(r_col_cnt);
        y0 = i_frame_start ? '0 : DIM_W'(r_row_cnt);
        if (x0 >= i_cfg.sw) begin
            x1 = '0;
            y1 = y0 + DIM_W'(1);
        end else begin
            x1 = x0;
            y1 = y0;
        end
        y2 = (y1 >= i_cfg.sh) ? '0 : y1;
        nx = x1 + DIM_W'(1);
        ny = y2;
        if (nx >= i_cfg.sw) begin
            nx = '0;
            ny = y2 + DIM_W'(1);
            if (ny >= i_cfg.sh) begin
                ny = '0;
            end
        end
    end

    always_comb begin
        case (i_cmd.div_sel)
            DIV_ROW_BEGIN: begin
                div_k = DIM_W'(r_cur_y);
                div_d = i_cfg.dh;
                div_s = i_cfg.sh;
            end
            DIV_ROW_END: begin
                div_k = DIM_W'(r_cur_y) + DIM_W'(1);
                div_d = i_cfg.dh;
                div_s = i_cfg.sh;
            end
            DIV_COL_BEGIN: begin
                div_k = DIM_W'(r_cur_x);
                div_d = i_cfg.dw;
                div_s = i_cfg.sw;
            end
            default: begin
                div_k = DIM_W'(r_cur_x) + DIM_W'(1);
                div_d = i_cfg.dw;
                div_s = i_cfg.sw;
            end
        endcase
        div_numer = (2*DIM_W)'(div_k) * (2*DIM_W)'(div_d);
    end

    nnfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_numer (div_numer),
        .i_denom (div_s),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        col_diff = r_col_end - r_col_begin;
        n_c_span = (col_diff > DIM_W'(MAX_SPAN)) ? SPAN_W'(MAX_SPAN)
                                                 : col_diff[SPAN_W-1:0];
        row_diff = r_row_end - r_row_begin;
        if (r_row_end > r_row_begin) begin
            n_r_span = (row_diff > DIM_W'(MAX_SPAN)) ? SPAN_W'(MAX_SPAN)
                                                     : row_diff[SPAN_W-1:0];
        end else begin
            n_r_span = SPAN_W'(1);
        end
        base_prod = (2*DIM_W)'(r_row_begin) * (2*DIM_W)'(i_cfg.dw);
        c_wrap    = ((r_c + SPAN_W'(1)) == r_c_span);
        beat_last = c_wrap && ((r_r + SPAN_W'(1)) == r_r_span);
        out_free  = !r_out_valid || !i_stall;
    end

    always_comb begin
        o_sts.div_done  = div_done;
        o_sts.row_hit   = r_row_ok && (r_row_key == r_cur_y);
        o_sts.col_hit   = r_col_ok && (r_col_key == DIM_W'(r_cur_x));
        o_sts.span_zero = (r_c_span == '0);
        o_sts.out_free  = out_free;
        o_sts.beat_last = beat_last;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt   <= '0;
            r_row_cnt   <= '0;
            r_row_ok    <= 1'b0;
            r_col_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_col_cnt <= nx[CNT_W-1:0];
                r_row_cnt <= ny[CNT_W-1:0];
            end
            if (div_done) begin
                case (r_div_sel)
                    DIV_ROW_BEGIN: r_row_ok <= 1'b0;
                    DIV_ROW_END:   r_row_ok <= 1'b1;
                    DIV_COL_END:   r_col_ok <= 1'b1;
                    default:       ;
                endcase
            end
            // dimensions may have changed: drop cached spans
            if (i_cfg_wr) begin
                r_row_ok <= 1'b0;
                r_col_ok <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur_x <= x1[CNT_W-1:0];
            r_cur_y <= y2[CNT_W-1:0];
            r_data  <= i_cfg.mode ? to_565(i_pixel) : i_pixel;
        end
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
        end
        if (i_cmd.col_reuse) begin
            r_col_begin <= r_col_end;
        end
        if (div_done) begin
            case (r_div_sel)
                DIV_ROW_BEGIN: r_row_begin <= div_quot;
                DIV_ROW_END: begin
                    r_row_end <= div_quot;
                    r_row_key <= r_cur_y;
                end
                DIV_COL_BEGIN: r_col_begin <= div_quot;
                default: begin
                    r_col_end <= div_quot;
                    r_col_key <= DIM_W'(r_cur_x) + DIM_W'(1);
                end
            endcase
        end
        if (i_cmd.setup) begin
            r_c_span   <= n_c_span;
            r_r_span   <= n_r_span;
            r_c        <= '0;
            r_r        <= '0;
            r_row_base <= base_prod[ADDR_W-1:0];
        end else if (i_cmd.emit) begin
            if (c_wrap) begin
                r_c        <= '0;
                r_r        <= r_r + SPAN_W'(1);
                r_row_base <= r_row_base + ADDR_W'(i_cfg.dw);
            end else begin
                r_c <= r_c + SPAN_W'(1);
            end
        end
        if (i_cmd.emit) begin
            o_address <= r_row_base + ADDR_W'(r_col_begin) + ADDR_W'(r_c);
            o_data    <= r_data;
            o_last    <= beat_last;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/core/nearest_neighbor_frame_scaler.sv
// Top level: register port, controller and datapath of the frame scaler.
//
// Each source pixel (raster order, frame_start marks the first) becomes up to
// MAX_SPAN x MAX_SPAN framebuffer write beats, row by row, left to right, the
// final one flagged by last. One pixel is in work at a time: first its divisions,
// then its write beats, if any (a pixel with an empty column span makes no write).
// The time is set by a 13-step restoring divider that yields one quotient bit
// per cycle and computes the column span end; its start is reused from the
// previous pixel. On a new source row, on the first pixel and after any
// register write, three more divisions run; a frame restart inside the same
// row adds one. Write beats leave through an output register, so the last beat may
// wait there without holding back the start of the next pixel.
// Write registers only while idle.
`default_nettype none

module nearest_neighbor_frame_scaler #(
    parameter int MAX_SPAN = nnfs_pkg::MAX_SPAN_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [nnfs_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [nnfs_pkg::APB_DW-1:0]   pwdata,
    output logic [nnfs_pkg::APB_DW-1:0]        prdata,
    output logic                               pready,
    // source pixels
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [nnfs_pkg::DATA_W-1:0]   i_pixel,
    input  wire logic                          i_frame_start,
    // framebuffer writes
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [nnfs_pkg::ADDR_W-1:0]        o_address,
    output logic [nnfs_pkg::DATA_W-1:0]        o_data,
    output logic                               o_last
);
    import nnfs_pkg::*;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            eff_dim = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            eff_dim = DIM_W'(MAX_DIM);
        end else begin
            eff_dim = v;
        end
    endfunction

    logic [DIM_W-1:0]     r_dest_width;
    logic [DIM_W-1:0]     r_dest_height;
    logic [DIM_W-1:0]     r_src_width;
    logic [DIM_W-1:0]     r_src_height;
    logic                 r_pixel_mode;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;
    t_cfg                 cfg;
    t_cmd                 cmd;
    t_sts                 sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_width  <= RST_DEST_WIDTH;
            r_dest_height <= RST_DEST_HEIGHT;
            r_src_width   <= RST_SRC_WIDTH;
            r_src_height  <= RST_SRC_HEIGHT;
            r_pixel_mode  <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_DEST_WIDTH:  r_dest_width  <= pwdata[DIM_W-1:0];
                REG_DEST_HEIGHT: r_dest_height <= pwdata[DIM_W-1:0];
                REG_SRC_WIDTH:   r_src_width   <= pwdata[DIM_W-1:0];
                REG_SRC_HEIGHT:  r_src_height  <= pwdata[DIM_W-1:0];
                REG_PIXEL_MODE:  r_pixel_mode  <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DEST_WIDTH:  prdata = APB_DW'(r_dest_width);
            REG_DEST_HEIGHT: prdata = APB_DW'(r_dest_height);
            REG_SRC_WIDTH:   prdata = APB_DW'(r_src_width);
            REG_SRC_HEIGHT:  prdata = APB_DW'(r_src_height);
            REG_PIXEL_MODE:  prdata = APB_DW'(r_pixel_mode);
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        cfg.dw   = eff_dim(r_dest_width);
        cfg.dh   = eff_dim(r_dest_height);
        cfg.sw   = eff_dim(r_src_width);
        cfg.sh   = eff_dim(r_src_height);
        cfg.mode = r_pixel_mode;
    end

    nnfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    nnfs_dp #(
        .MAX_SPAN (MAX_SPAN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cfg_wr      (cfg_wr),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_address     (o_address),
        .o_data        (o_data),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

// File: sim/nearest_neighbor_frame_scaler_test.sv
// Self-checking testbench for the nearest-neighbor frame scaler.
`timescale 1ns / 100ps

module nearest_neighbor_frame_scaler_test;
    import nnfs_pkg::*;

    localparam int SPAN_LIMIT     = MAX_SPAN_DEFAULT;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 140;
    localparam int CALM_AFTER     = 105;

    typedef struct {
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_fb_write;

    // Tracks scaler registers and source counters, queues the framebuffer writes due.
    class t_fb_write_model;
        int unsigned dest_w = RST_DEST_WIDTH;
        int unsigned dest_h = RST_DEST_HEIGHT;
        int unsigned src_w  = RST_SRC_WIDTH;
        int unsigned src_h  = RST_SRC_HEIGHT;
        bit          rgb565 = 1'b0;
        int unsigned col    = 0;
        int unsigned row    = 0;
        t_fb_write   pending_writes[$];
        int          errors = 0;

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_DEST_WIDTH:  dest_w = value[12:0];
                REG_DEST_HEIGHT: dest_h = value[12:0];
                REG_SRC_WIDTH:   src_w = value[12:0];
                REG_SRC_HEIGHT:  src_h = value[12:0];
                REG_PIXEL_MODE:  rgb565 = value[0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(int unsigned v);
            if (v == 0) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return v;
        endfunction

        function void take_pixel(logic [DATA_W-1:0] pixel, logic frame_start);
            int unsigned dw, dh, sw, sh, x0, x1, y0, y1, ncol, nrow;
            logic [DATA_W-1:0] word;
            t_fb_write w;
            dw = clamp_dim(dest_w);
            dh = clamp_dim(dest_h);
            sw = clamp_dim(src_w);
            sh = clamp_dim(src_h);
            if (frame_start) begin
                col = 0;
                row = 0;
            end
            // counters left past the frame by a register change
            if (col >= sw) begin
                col = 0;
                row++;
            end
            if (row >= sh) row = 0;

            x0 = col * dw / sw;
            x1 = (col + 1) * dw / sw;
            y0 = row * dh / sh;
            y1 = (row + 1) * dh / sh;
            y1 = (y1 > y0) ? y1 - 1 : y0;
            ncol = x1 - x0;
            if (ncol > SPAN_LIMIT) ncol = SPAN_LIMIT;
            nrow = y1 - y0 + 1;
            if (nrow > SPAN_LIMIT) nrow = SPAN_LIMIT;

            word = rgb565 ? {16'h0000, pixel[23:19], pixel[15:10], pixel[7:3]} : pixel;
            for (int r = 0; r < nrow && ncol > 0; r++) begin
                for (int c = 0; c < ncol; c++) begin
                    w.address = ADDR_W'((y0 + r) * dw + x0 + c);
                    w.data    = word;
                    w.last    = 1'b0;
                    pending_writes.push_back(w);
                end
            end
            if (ncol > 0) pending_writes[pending_writes.size() - 1].last = 1'b1;

            col++;
            if (col >= sw) begin
                col = 0;
                row++;
                if (row >= sh) row = 0;
            end
        endfunction

        function void match_write(logic [ADDR_W-1:0] address, logic [DATA_W-1:0] data,
                                  logic last);
            t_fb_write want;
            if (pending_writes.size() == 0) begin
                errors++;
                $display("%0t: write beat with none expected: address %h data %h last %b",
                         $time, address, data, last);
                return;
            end
            want = pending_writes.pop_front();
            if (address !== want.address) begin
                errors++;
                $display("%0t: address expected %h actual %h", $time, want.address, address);
            end
            if (data !== want.data) begin
                errors++;
                $display("%0t: data expected %h actual %h (address %h)",
                         $time, want.data, data, want.address);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last expected %b actual %b (address %h)",
                         $time, want.last, last, want.address);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [DATA_W-1:0]    i_pixel = '0;
    logic                 i_frame_start = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [ADDR_W-1:0]    o_address;
    logic [DATA_W-1:0]    o_data;
    logic                 o_last;

    t_fb_write_model model;
    bit              calm = 1'b0;
    int              stall_left = 0;
    int              run_left = 0;
    int              quiet_cycles = 0;

    nearest_neighbor_frame_scaler uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_address     (o_address),
        .o_data        (o_data),
        .o_last        (o_last)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // write side back-pressure: stall bursts between runs of free cycles
    always @(negedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (run_left > 0) begin
            i_stall <= 1'b0;
            run_left--;
        end else begin
            i_stall <= 1'b0;
            if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 16);
            else if ($urandom_range(0, 5) == 0) run_left = $urandom_range(60, 150);
            else run_left = $urandom_range(1, 30);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) model.match_write(o_address, o_data, o_last);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles, %0d writes outstanding",
                     $time, quiet_cycles, model.pending_writes.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        model.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_pixel(input logic [DATA_W-1:0] pixel, input logic frame_start);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_pixel       <= pixel;
        i_frame_start <= frame_start;
        do @(posedge i_clk); while (o_stall);
        model.take_pixel(pixel, frame_start);
    endtask

    // drop valid, let every queued write drain, then allow for a pixel still in work
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (model.pending_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned dw, input int unsigned dh,
                             input int unsigned sw, input int unsigned sh, input bit mode);
        settle();
        write_reg(REG_DEST_WIDTH, dw);
        write_reg(REG_DEST_HEIGHT, dh);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_PIXEL_MODE, mode);
    endtask

    function automatic int unsigned pick_dim();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(MAX_DIM + 1, 8191);
            2:       return $urandom_range(1, MAX_DIM);
            3:       return MAX_DIM;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    initial begin
        int random_sent;
        int count;
        bit resync;
        model = new();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values: 1:1 at full HD
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'hffff_ffff, 1'b0);

        // uneven upscale, end-of-frame wrap, restart mid-frame
        configure(5, 3, 2, 2, 1'b0);
        send_pixel(32'h00ff_0000, 1'b1);
        send_pixel(32'h0000_ff00, 1'b0);
        send_pixel(32'h0000_00ff, 1'b0);
        send_pixel(32'hff00_0000, 1'b0);
        send_pixel(32'h1234_5678, 1'b0);
        send_pixel(32'h8765_4321, 1'b1);

        // zero and oversize dims, empty column spans, row span cap, RGB565
        configure(0, 8191, 3, 1, 1'b1);
        send_pixel(32'hffff_ffff, 1'b1);
        send_pixel(32'haaaa_aaaa, 1'b0);
        send_pixel(32'h5555_5555, 1'b0);

        // both spans capped: 64 beats per pixel
        configure(MAX_DIM, MAX_DIM, 0, 0, 1'b0);
        send_pixel(32'hdead_beef, 1'b1);
        send_pixel(32'h0101_0101, 1'b0);

        // shrink the source frame under the counters
        configure(6, 3, 6, 3, 1'b1);
        send_pixel(32'h00f8_fcf8, 1'b1);
        send_pixel(32'h0007_0307, 1'b0);
        send_pixel(32'hc0ff_ee00, 1'b0);
        send_pixel(32'h0080_4020, 1'b0);
        settle();
        write_reg(REG_SRC_WIDTH, 2);
        send_pixel(32'h7f7f_7f7f, 1'b0);
        send_pixel(32'h8080_8080, 1'b0);
        settle();
        write_reg(REG_SRC_HEIGHT, 1);
        write_reg(REG_PIXEL_MODE, 0);
        send_pixel(32'h0f0f_f0f0, 1'b0);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= CALM_AFTER) calm = 1'b1;
            configure(pick_dim(), pick_dim(), pick_dim(), pick_dim(), $urandom_range(0, 1));
            // mostly fresh frames; the rest carry the counters over the new setup
            resync = ($urandom_range(0, 2) != 0);
            count = $urandom_range(6, 24);
            for (int k = 0; k < count; k++) begin
                send_pixel($urandom(), (k == 0) ? resync : ($urandom_range(0, 15) == 0));
            end
            random_sent += count;
        end

        settle();
        if (model.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
